// ===== design/indexed_shift_array_assert.svh =====
// Assertion macros used by the checker file of the indexed shift array.
// Depends on nothing; the including module must provide clk and arst_n.
`ifndef INDEXED_SHIFT_ARRAY_ASSERT_SVH
`define INDEXED_SHIFT_ARRAY_ASSERT_SVH

// Property checked on every rising clock edge outside reset.
`define ISA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication from one cycle into the next, outside reset.
`define ISA_ASSERT_NEXT(lbl, cond, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

// ===== design/isa_pkg.sv =====
// Package of the indexed shift array: sizes, command codes and the control
// bundle broadcast to the cells. Depends on nothing.
package isa_pkg;

	// Array geometry.
	localparam int DEPTH     = 16;
	localparam int ELEM_W    = 32;
	localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W     = $clog2(DEPTH + 1);

	// Fixed port widths.
	localparam int CMD_W     = 3;
	localparam int INDEX_W   = 5;
	localparam int VALUE_W   = 32;
	localparam int COUNT_W   = 5;
	localparam int CAP_W     = 5;

	// Position arithmetic must hold both the index port and the depth.
	localparam int POS_W     = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
	// Common width for moving data between the value ports and elements.
	localparam int WIDE_W    = (ELEM_W > VALUE_W) ? ELEM_W : VALUE_W;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	// Commands accepted on the request port.
	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT      = 3'd0,
		CMD_INSERT_ZERO = 3'd1,
		CMD_REMOVE      = 3'd2,
		CMD_UPDATE      = 3'd3,
		CMD_READ        = 3'd4,
		CMD_CLEAR       = 3'd5,
		CMD_FILL        = 3'd6
	} cmd_t;

	// Operation the cells carry out at each clock edge.
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE,
		CELL_UPDATE,
		CELL_FILL
	} cell_op_t;

	// Control broadcast from the top level to every cell.
	typedef struct packed {
		cell_op_t           op;
		logic [POS_W-1:0]   pos;
		logic [POS_W-1:0]   cnt;
		logic [POS_W-1:0]   lim;
		logic [ELEM_W-1:0]  data;
	} isa_ctrl_t;

endpackage

// ===== design/isa_cell.sv =====
// One slot of the indexed shift array: holds an element and takes its next
// value from itself, a neighbor, the request data or zero. Uses isa_pkg.
module isa_cell (
	input  logic                          clk,
	input  logic [isa_pkg::POS_W-1:0]     cell_index,
	input  isa_pkg::isa_ctrl_t            ctrl,
	input  logic [isa_pkg::ELEM_W-1:0]    left_elem,
	input  logic [isa_pkg::ELEM_W-1:0]    right_elem,
	output logic [isa_pkg::ELEM_W-1:0]    elem
);

	logic [isa_pkg::ELEM_W-1:0] elem_q;
	logic [isa_pkg::ELEM_W-1:0] elem_d;
	logic [isa_pkg::POS_W-1:0]  index_next;

	assign index_next = cell_index + isa_pkg::POS_W'(1);

	// Choose the next content of this slot from the broadcast operation.
	always_comb begin
		elem_d = elem_q;
		case (ctrl.op)
			isa_pkg::CELL_INSERT: begin
				if (cell_index == ctrl.pos) begin
					elem_d = ctrl.data;
				end else if (cell_index > ctrl.pos && cell_index <= ctrl.cnt) begin
					elem_d = left_elem;
				end
			end
			isa_pkg::CELL_REMOVE: begin
				if (index_next == ctrl.cnt) begin
					elem_d = '0;
				end else if (cell_index >= ctrl.pos && index_next < ctrl.cnt) begin
					elem_d = right_elem;
				end
			end
			isa_pkg::CELL_UPDATE: begin
				if (cell_index == ctrl.pos) begin
					elem_d = ctrl.data;
				end
			end
			isa_pkg::CELL_FILL: begin
				if (cell_index >= ctrl.cnt && cell_index < ctrl.lim) begin
					elem_d = '0;
				end
			end
			default: begin
				elem_d = elem_q;
			end
		endcase
	end

	// Element storage; contents are undefined until first written.
	always_ff @(posedge clk) begin
		elem_q <= elem_d;
	end

	assign elem = elem_q;

endmodule

// ===== design/indexed_shift_array.sv =====
// Indexed shift array: a bounded ordered list of elements held in a row of
// cells, each shifting toward its neighbor when an entry is inserted or removed.
//
// Use: a request is taken at a rising edge with start high and busy low;
// busy is always low, so a request may be given in every cycle. Fields are
// command, index, at_tail and value. In the cycle after the request, done is
// high for exactly one cycle with ok, read_value and count; the receiver
// cannot hold results off, and count keeps showing the live count.
// Throughput is one request per cycle: all cells shift in parallel in the
// cycle the request is taken, and the result registers are loaded at the
// same edge.
// The capacity register is written at any edge with cfg_we high; the user
// must keep writes between requests, as the block does not enforce it.
// Values above the depth act as the depth. Reset (arst_n low) empties the
// array and sets capacity to 16. Element contents are not cleared; only
// written entries are ever read. Depends on isa_pkg and isa_cell.
module indexed_shift_array (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [isa_pkg::CMD_W-1:0]     command,
	input  logic [isa_pkg::INDEX_W-1:0]   index,
	input  logic                          at_tail,
	input  logic [isa_pkg::VALUE_W-1:0]   value,
	input  logic                          cfg_we,
	input  logic [isa_pkg::CAP_W-1:0]     cfg_wdata,
	output logic                          done,
	output logic                          ok,
	output logic [isa_pkg::VALUE_W-1:0]   read_value,
	output logic [isa_pkg::COUNT_W-1:0]   count
);

	localparam int POS_W  = isa_pkg::POS_W;
	localparam int ELEM_W = isa_pkg::ELEM_W;
	localparam int WIDE_W = isa_pkg::WIDE_W;

	logic [isa_pkg::CAP_W-1:0]  capacity_q;
	logic [POS_W-1:0]           count_q;
	logic                       done_q;
	logic                       ok_q;
	logic [isa_pkg::VALUE_W-1:0] read_value_q;

	logic                       accept;
	logic [POS_W-1:0]           cap_ext;
	logic [POS_W-1:0]           lim;
	logic [POS_W-1:0]           idx_ext;
	logic [POS_W-1:0]           pos;
	logic                       pos_valid;
	logic [POS_W-1:0]           ins_pos;
	logic                       ins_ok;
	logic [WIDE_W-1:0]          value_wide;
	logic [WIDE_W-1:0]          rd_wide;
	logic [ELEM_W-1:0]          rd_elem;
	isa_pkg::isa_ctrl_t         ctrl;
	logic                       ok_d;
	logic [isa_pkg::VALUE_W-1:0] read_value_d;
	logic [POS_W-1:0]           count_d;

	logic [ELEM_W-1:0]          elems [isa_pkg::DEPTH];

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Capacity clipped to the depth, and the positions the request names.
	assign cap_ext   = POS_W'(capacity_q);
	assign lim       = (cap_ext > POS_W'(isa_pkg::DEPTH)) ? POS_W'(isa_pkg::DEPTH) : cap_ext;
	assign idx_ext   = POS_W'(index);
	assign pos       = at_tail ? ((count_q != '0) ? count_q - POS_W'(1) : '0) : idx_ext;
	assign pos_valid = at_tail ? (count_q != '0) : (idx_ext < count_q);
	assign ins_pos   = at_tail ? count_q : idx_ext;
	assign ins_ok    = (count_q < lim) && (ins_pos <= count_q);

	assign value_wide = WIDE_W'(value);
	assign rd_elem    = elems[pos[isa_pkg::IDX_W-1:0]];
	assign rd_wide    = WIDE_W'(rd_elem);

	// Decode the request into a cell operation and the result fields.
	always_comb begin
		ctrl.op      = isa_pkg::CELL_HOLD;
		ctrl.pos     = pos;
		ctrl.cnt     = count_q;
		ctrl.lim     = lim;
		ctrl.data    = value_wide[ELEM_W-1:0];
		ok_d         = 1'b0;
		read_value_d = '0;
		count_d      = count_q;
		if (accept) begin
			unique case (command)
				isa_pkg::CMD_INSERT, isa_pkg::CMD_INSERT_ZERO: begin
					ctrl.pos = ins_pos;
					if (command == isa_pkg::CMD_INSERT_ZERO) begin
						ctrl.data = '0;
					end
					if (ins_ok) begin
						ctrl.op = isa_pkg::CELL_INSERT;
						ok_d    = 1'b1;
						count_d = count_q + POS_W'(1);
					end
				end
				isa_pkg::CMD_REMOVE: begin
					if (pos_valid) begin
						ctrl.op      = isa_pkg::CELL_REMOVE;
						ok_d         = 1'b1;
						read_value_d = rd_wide[isa_pkg::VALUE_W-1:0];
						count_d      = count_q - POS_W'(1);
					end
				end
				isa_pkg::CMD_UPDATE: begin
					if (pos_valid) begin
						ctrl.op = isa_pkg::CELL_UPDATE;
						ok_d    = 1'b1;
					end
				end
				isa_pkg::CMD_READ: begin
					if (pos_valid) begin
						ok_d         = 1'b1;
						read_value_d = rd_wide[isa_pkg::VALUE_W-1:0];
					end
				end
				isa_pkg::CMD_CLEAR: begin
					ok_d    = 1'b1;
					count_d = '0;
				end
				isa_pkg::CMD_FILL: begin
					ctrl.op = isa_pkg::CELL_FILL;
					ok_d    = 1'b1;
					count_d = lim;
				end
				default: begin
					ok_d = 1'b0;
				end
			endcase
		end
	end

	// Row of cells; the end cells see zero past the edge.
	for (genvar g = 0; g < isa_pkg::DEPTH; g++) begin : g_cell
		logic [ELEM_W-1:0] left_w;
		logic [ELEM_W-1:0] right_w;
		if (g == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_left
			assign left_w = elems[g-1];
		end
		if (g == isa_pkg::DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_right
			assign right_w = elems[g+1];
		end
		isa_cell u_cell (
			.clk        (clk),
			.cell_index (POS_W'(g)),
			.ctrl       (ctrl),
			.left_elem  (left_w),
			.right_elem (right_w),
			.elem       (elems[g])
		);
	end

	// Control state: capacity, live count and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= isa_pkg::CAP_RESET;
			count_q    <= '0;
			done_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			count_q <= count_d;
			done_q  <= accept;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		ok_q         <= ok_d;
		read_value_q <= read_value_d;
	end

	assign done       = done_q;
	assign ok         = ok_q;
	assign read_value = read_value_q;
	assign count      = count_q[isa_pkg::COUNT_W-1:0];

endmodule

// ===== design/isa_checker.sv =====
// Port checker of the indexed shift array, bound to the top level.
// Depends on isa_pkg and indexed_shift_array_assert.svh.
`include "indexed_shift_array_assert.svh"

module isa_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic                          ok,
	input logic [isa_pkg::VALUE_W-1:0]   read_value,
	input logic [isa_pkg::COUNT_W-1:0]   count
);

	// Every taken request gets its result in the next cycle, and no other.
	`ISA_ASSERT_NEXT(a_done_follows, start && !busy, done, "result missing after request")
	`ISA_ASSERT_NEXT(a_no_spurious, !(start && !busy), !done, "result without request")
	// A rejected request returns no data.
	`ISA_ASSERT(a_reject_zero, done && !ok |-> read_value == '0, "rejected request returned data")
	// The live count never passes the depth.
	`ISA_ASSERT(a_count_bound, count <= isa_pkg::COUNT_W'(isa_pkg::DEPTH), "count beyond depth")
	// Without a request the live count holds.
	`ISA_ASSERT_NEXT(a_count_hold, !(start && !busy), $stable(count), "count moved while idle")

endmodule

bind indexed_shift_array isa_checker u_isa_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.ok         (ok),
	.read_value (read_value),
	.count      (count)
);
